@@ src/bwlp_pkg.sv @@
// Shared widths, fixed-point constants and unit request types for the Butterworth lowpass.
package bwlp_pkg;

  localparam int MacW  = 41;  // multiplier operand width, signed
  localparam int AccW  = 66;  // product accumulator width, signed
  localparam int DivNW = 66;  // divider dividend width
  localparam int DivDW = 40;  // divider divisor width
  localparam int FracW = 28;  // Q28 coefficient fraction
  localparam int PowW  = 36;  // width of wn powers and rounded products
  localparam int YW    = 24;  // Q1.23 output history

  localparam logic [30:0] TwoPiQ = 31'd1686629713;
  localparam logic [28:0] KQ     = 29'd350727825;
  localparam logic [31:0] PQ     = 32'd3665983898;

  typedef struct packed {
    logic                   start;
    logic                   sub;
    logic signed [MacW-1:0] a;
    logic signed [MacW-1:0] b;
    logic signed [AccW-1:0] init;
  } mac_req_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ src/bwlp_mac.sv @@
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
module bwlp_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bwlp_pkg::mac_req_t                  req_i,
  output bwlp_pkg::unit_sts_t                 sts_o,
  output logic signed [bwlp_pkg::AccW-1:0]    acc_o
);
  import bwlp_pkg::*;

  localparam int CntW = $clog2(MacW);

  logic signed [AccW-1:0] acc_q, a_q, term;
  logic [MacW-1:0]        b_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q, sub_q, last;

  assign last = (cnt_q == CntW'(MacW - 1));

  // The sign bit of b carries negative weight; sub flips every partial product.
  always_comb begin
    if (b_q[0]) begin
      term = (last ^ sub_q) ? -a_q : a_q;
    end else begin
      term = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.init;
      a_q   <= AccW'(req_i.a);
      b_q   <= req_i.b;
      sub_q <= req_i.sub;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

@@ src/bwlp_div.sv @@
// Restoring unsigned divider: one quotient bit per cycle.
module bwlp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bwlp_pkg::div_req_t            req_i,
  output bwlp_pkg::unit_sts_t           sts_o,
  output logic [bwlp_pkg::DivNW-1:0]    quo_o
);
  import bwlp_pkg::*;

  localparam int CntW = $clog2(DivNW);

  logic [DivDW-1:0] rem_q, dvs_q;
  logic [DivNW-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q, last, ge;
  logic [DivDW:0]   trial;
  logic [DivDW+1:0] diff;

  assign last  = (cnt_q == CntW'(DivNW - 1));
  assign trial = {rem_q, quo_q[DivNW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = !diff[DivDW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
      quo_q <= {quo_q[DivNW-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

@@ src/butterworth_lowpass4_iir.sv @@
// Fourth-order Butterworth lowpass top level: sequencer, history and stream ports.
// One sample is processed at a time, from input accept to output valid.
// Twelve products run through the bit-serial multiplier, and two quotients
// (cutoff scaling, output) through the restoring divider.
// A new sample is accepted only once the previous result has entered the output register.
// A finished result waits in the output register while the next sample is accepted.
// Reset (rst_ni low, asynchronous) clears both history lines and all handshake state.
module butterworth_lowpass4_iir #(
  parameter int SAMPLE_RATE = 48000,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [SAMPLE_BITS-1:0] sample_in, [SAMPLE_BITS+14:SAMPLE_BITS] cutoff_hz, zero fill above
  input  logic [((SAMPLE_BITS+15+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // [SAMPLE_BITS-1:0] sample_out, zero fill above
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // [0] saturated
  output logic                                     m_axis_tuser
);
  import bwlp_pkg::*;

  localparam int OutW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int XsW  = SAMPLE_BITS + 4;
  localparam logic [17:0] HalfSr = 18'(SAMPLE_RATE / 2);
  localparam logic [17:0] Rate   = 18'(SAMPLE_RATE);
  localparam logic signed [MacW-1:0] OneQ  = MacW'(64'sd268435456);
  localparam logic signed [AccW-1:0] HalfQ = AccW'(64'sd134217728);
  localparam logic [DivNW-1:0] YMaxQ = DivNW'(64'd8388607);
  localparam logic [DivNW-1:0] YMinQ = DivNW'(64'd8388608);
  localparam logic signed [YW-1:0] YMax = 24'sh7FFFFF;
  localparam logic signed [YW-1:0] YMin = 24'sh800000;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LAUNCH = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_COEF   = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  localparam logic [3:0] OP_U_MUL = 4'd0;
  localparam logic [3:0] OP_U_DIV = 4'd1;
  localparam logic [3:0] OP_U2    = 4'd2;
  localparam logic [3:0] OP_U3    = 4'd3;
  localparam logic [3:0] OP_U4    = 4'd4;
  localparam logic [3:0] OP_KW    = 4'd5;
  localparam logic [3:0] OP_PW2   = 4'd6;
  localparam logic [3:0] OP_KW3   = 4'd7;
  localparam logic [3:0] OP_NFF   = 4'd8;
  localparam logic [3:0] OP_NC    = 4'd9;
  localparam logic [3:0] OP_ND    = 4'd10;
  localparam logic [3:0] OP_NE    = 4'd11;
  localparam logic [3:0] OP_NF    = 4'd12;
  localparam logic [3:0] OP_Y_DIV = 4'd13;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [14:0]                   fc_q;
  logic [PowW-1:0]               u_q, u2_q, u3_q, u4_q, kw_q, pw2_q, kw3_q;
  logic signed [MacW-1:0]        c_q, d_q, e_q, f_q, g_q;
  logic                          neg_q;
  logic signed [SAMPLE_BITS-1:0] xh_q [4];
  logic signed [YW-1:0]          yh_q [4];
  logic                          m_valid_q;
  logic [SAMPLE_BITS-1:0]        m_data_q;
  logic                          m_sat_q;

  mac_req_t               mac_req;
  div_req_t               div_req;
  unit_sts_t              mac_sts, div_sts;
  logic signed [AccW-1:0] mac_acc;
  logic [DivNW-1:0]       div_quo;

  logic                   is_div, unit_done, out_load, in_acc;
  logic [17:0]            fc_c;
  logic [PowW-1:0]        rnd;
  logic signed [XsW-1:0]  xs;
  logic signed [27:0]     xsc;
  logic signed [MacW-1:0] kw_s, pw2_s, kw3_s, w4_s;
  logic signed [MacW-1:0] c_c, d_c, e_c, f_c, g_c;
  logic [AccW-1:0]        mag;
  logic signed [YW-1:0]   y_c;
  logic                   sat_c;

  bwlp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .sts_o  (mac_sts),
    .acc_o  (mac_acc)
  );

  bwlp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_div    = (step_q == OP_U_DIV) || (step_q == OP_Y_DIV);
  assign unit_done = is_div ? div_sts.done : mac_sts.done;
  assign rnd       = mac_acc[FracW+PowW-1:FracW];
  assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // Clamp the cutoff to 1 Hz .. SAMPLE_RATE/2.
  always_comb begin
    if (fc_q == '0) begin
      fc_c = 18'd1;
    end else if (18'(fc_q) > HalfSr) begin
      fc_c = HalfSr;
    end else begin
      fc_c = 18'(fc_q);
    end
  end

  assign xs  = XsW'(x_q) + ((XsW'(xh_q[0]) + XsW'(xh_q[2])) <<< 2)
             + (XsW'(xh_q[1]) <<< 2) + (XsW'(xh_q[1]) <<< 1) + XsW'(xh_q[3]);
  assign xsc = 28'(xs) <<< (YW - SAMPLE_BITS);

  assign kw_s  = $signed({5'b0, kw_q});
  assign pw2_s = $signed({5'b0, pw2_q});
  assign kw3_s = $signed({5'b0, kw3_q});
  assign w4_s  = $signed({5'b0, u4_q});

  assign c_c = (OneQ <<< 4) - (kw_s <<< 4) + pw2_s - (kw3_s <<< 2) + w4_s;
  assign d_c = (kw_s <<< 5) - (OneQ <<< 6) - (kw3_s <<< 3) + (w4_s <<< 2);
  assign e_c = (OneQ <<< 6) + (OneQ <<< 5) - (pw2_s <<< 1) + (w4_s <<< 2) + (w4_s <<< 1);
  assign f_c = (kw3_s <<< 3) - (OneQ <<< 6) - (kw_s <<< 5) + (w4_s <<< 2);
  assign g_c = (OneQ <<< 4) + (kw_s <<< 4) + pw2_s + (kw3_s <<< 2) + w4_s;

  assign mag = mac_acc[AccW-1] ? AccW'(-mac_acc) : AccW'(mac_acc);

  always_comb begin
    mac_req       = '0;
    mac_req.start = (state_q == ST_LAUNCH) && !is_div;
    mac_req.init  = HalfQ;
    case (step_q)
      OP_U_MUL: begin
        mac_req.a    = MacW'($signed({1'b0, TwoPiQ}));
        mac_req.b    = MacW'($signed({1'b0, fc_c}));
        mac_req.init = AccW'($signed({1'b0, HalfSr}));
      end
      OP_U2: begin
        mac_req.a = MacW'($signed({1'b0, u_q}));
        mac_req.b = MacW'($signed({1'b0, u_q}));
      end
      OP_U3: begin
        mac_req.a = MacW'($signed({1'b0, u2_q}));
        mac_req.b = MacW'($signed({1'b0, u_q}));
      end
      OP_U4: begin
        mac_req.a = MacW'($signed({1'b0, u2_q}));
        mac_req.b = MacW'($signed({1'b0, u2_q}));
      end
      OP_KW: begin
        mac_req.a = MacW'($signed({1'b0, KQ}));
        mac_req.b = MacW'($signed({1'b0, u_q}));
      end
      OP_PW2: begin
        mac_req.a = MacW'($signed({1'b0, PQ}));
        mac_req.b = MacW'($signed({1'b0, u2_q}));
      end
      OP_KW3: begin
        mac_req.a = MacW'($signed({1'b0, KQ}));
        mac_req.b = MacW'($signed({1'b0, u3_q}));
      end
      OP_NFF: begin
        mac_req.a    = w4_s;
        mac_req.b    = MacW'(xsc);
        mac_req.init = '0;
      end
      OP_NC: begin
        mac_req.a    = c_q;
        mac_req.b    = MacW'(yh_q[3]);
        mac_req.init = mac_acc;
        mac_req.sub  = 1'b1;
      end
      OP_ND: begin
        mac_req.a    = d_q;
        mac_req.b    = MacW'(yh_q[2]);
        mac_req.init = mac_acc;
        mac_req.sub  = 1'b1;
      end
      OP_NE: begin
        mac_req.a    = e_q;
        mac_req.b    = MacW'(yh_q[1]);
        mac_req.init = mac_acc;
        mac_req.sub  = 1'b1;
      end
      OP_NF: begin
        mac_req.a    = f_q;
        mac_req.b    = MacW'(yh_q[0]);
        mac_req.init = mac_acc;
        mac_req.sub  = 1'b1;
      end
      default: begin
        mac_req.a = '0;
        mac_req.b = '0;
      end
    endcase
  end

  always_comb begin
    div_req       = '0;
    div_req.start = (state_q == ST_LAUNCH) && is_div;
    if (step_q == OP_Y_DIV) begin
      // Round half away from zero: add half the divisor to the magnitude.
      div_req.dividend = DivNW'(mag) + DivNW'(g_q[DivDW-1:1]);
      div_req.divisor  = g_q[DivDW-1:0];
    end else begin
      div_req.dividend = DivNW'(mac_acc);
      div_req.divisor  = DivDW'(Rate);
    end
  end

  always_comb begin
    sat_c = 1'b0;
    if (!neg_q && (div_quo > YMaxQ)) begin
      y_c   = YMax;
      sat_c = 1'b1;
    end else if (neg_q && (div_quo > YMinQ)) begin
      y_c   = YMin;
      sat_c = 1'b1;
    end else if (neg_q) begin
      y_c = -$signed(div_quo[YW-1:0]);
    end else begin
      y_c = $signed(div_quo[YW-1:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LAUNCH;
          step_d  = OP_U_MUL;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (unit_done) begin
          if (step_q == OP_KW3) begin
            state_d = ST_COEF;
          end else if (step_q == OP_Y_DIV) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_LAUNCH;
            step_d  = step_q + 1'b1;
          end
        end
      end
      ST_COEF: begin
        state_d = ST_LAUNCH;
        step_d  = OP_NFF;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= OP_U_MUL;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
        xh_q[0]   <= x_q;
        yh_q[0]   <= y_c;
        for (int i = 1; i < 4; i++) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= yh_q[i-1];
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      fc_q <= s_axis_tdata[SAMPLE_BITS+14:SAMPLE_BITS];
    end
    if (state_q == ST_WAIT && unit_done) begin
      case (step_q)
        OP_U_DIV: u_q   <= div_quo[PowW-1:0];
        OP_U2:    u2_q  <= rnd;
        OP_U3:    u3_q  <= rnd;
        OP_U4:    u4_q  <= rnd;
        OP_KW:    kw_q  <= rnd;
        OP_PW2:   pw2_q <= rnd;
        OP_KW3:   kw3_q <= rnd;
        OP_NF:    neg_q <= mac_acc[AccW-1];
        default: begin
        end
      endcase
    end
    if (state_q == ST_COEF) begin
      c_q <= c_c;
      d_q <= d_c;
      e_q <= e_c;
      f_q <= f_c;
      g_q <= g_c;
    end
    if (out_load) begin
      m_data_q <= y_c[YW-1:YW-SAMPLE_BITS];
      m_sat_q  <= sat_c;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutW'(m_data_q);
  assign m_axis_tuser  = m_sat_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("accepted request did not start the sequencer");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result appeared outside the output step");

  a_ready_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!mac_sts.busy && !div_sts.busy))
    else $error("input ready while an arithmetic unit is busy");
`endif

endmodule
